>>> rtl/token_pair_rank_hash_table_unit_assert.svh
// ----------------------------------------------------------------------------
// token pair rank hash table assertion macros
// concurrent assertion wrappers on clock and reset, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef TOKEN_PAIR_RANK_HASH_TABLE_UNIT_ASSERT_SVH
`define TOKEN_PAIR_RANK_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TPRH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TPRH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TPRH_ASSERT_SAME(label, ante, cons, msg)
`define TPRH_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/tprh_pkg.sv
// ----------------------------------------------------------------------------
// tprh_pkg
// shared constants, codes and types of the token pair rank hash table
// ----------------------------------------------------------------------------
package tprh_pkg;

   localparam int TABLE_SLOTS = 4096;

   localparam int              SIZE_LOG2_W     = 4;
   localparam logic [3:0]      SIZE_LOG2_RESET = 4'd12;

   // epoch tag stored with each slot, zero never live
   localparam int EPOCH_W = 8;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUP       = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // murmur3 fmix64 constants
   localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT = 33;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [63:0]        key;
      logic [31:0]        rank;
   } slot_type;

endpackage

>>> rtl/tprh_if.sv
// ----------------------------------------------------------------------------
// tprh channel interfaces
// valid/ready channels for request items, response items and the size register
// ----------------------------------------------------------------------------
interface tprh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] left_id;
   logic [31:0] right_id;
   logic [31:0] rank_in;

   modport source (output valid, output op, output left_id, output right_id,
                   output rank_in, input ready);
   modport sink   (input valid, input op, input left_id, input right_id,
                   input rank_in, output ready);
endinterface

interface tprh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        found;
   logic [31:0] rank_out;

   modport source (output valid, output status, output found, output rank_out,
                   input ready);
   modport sink   (input valid, input status, input found, input rank_out,
                   output ready);
endinterface

interface tprh_csr_if import tprh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SIZE_LOG2_W-1:0] size_log2;

   modport source (output valid, output size_log2, input ready);
   modport sink   (input valid, input size_log2, output ready);
endinterface

>>> rtl/tprh_ram.sv
// ----------------------------------------------------------------------------
// tprh_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tprh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tprh_mix.sv
// ----------------------------------------------------------------------------
// tprh_mix
// murmur3 fmix64 on one shared 32x32 multiplier, low 32 bits of the result
// ----------------------------------------------------------------------------
module tprh_mix import tprh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   output logic        done,
   output logic [31:0] hash
);

   localparam logic [2:0] LastStep = 3'd4;

   logic        busy_ff, busy_in;
   logic        round_ff, round_in;
   logic [2:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;

   logic [63:0] mult_c;
   logic [31:0] mult_a;
   logic [31:0] mult_b;
   logic        finish;

   // partial products: lo*lo, hi*lo, lo*hi (upper terms only need low half)
   always_comb begin
      mult_c  = round_ff ? MIX_C2 : MIX_C1;
      mult_a  = (step_ff == 3'd1) ? x_ff[63:32] : x_ff[31:0];
      mult_b  = (step_ff == 3'd2) ? mult_c[63:32] : mult_c[31:0];
      prod_in = mult_a * mult_b;
   end

   assign finish = busy_ff && (step_ff == LastStep) && round_ff;

   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      done_in  = finish;
      if (start) begin
         busy_in  = 1'b1;
         round_in = 1'b0;
         step_in  = '0;
         x_in     = key ^ (key >> MIX_SHIFT);
      end else if (busy_ff) begin
         case (step_ff)
            3'd1: begin
               acc_in = prod_ff;
            end
            3'd2, 3'd3: begin
               acc_in = acc_ff + {prod_ff[31:0], 32'b0};
            end
            LastStep: begin
               x_in = acc_ff ^ (acc_ff >> MIX_SHIFT);
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (step_ff == LastStep) begin
            step_in  = '0;
            round_in = 1'b1;
            busy_in  = !round_ff;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign hash = x_ff[31:0];

endmodule

>>> rtl/token_pair_rank_hash_table_unit.sv
// lookup/insert: fmix64 hash, then a linear probe walk; fmix64 runs on one shared
// 32x32 multiplier, each linear probe step is one ram read then one compare
// clear: epoch bump, or a tag sweep when the epoch tag wraps (once per 255 clears)
// throughput: one item at a time, next item taken once the result is registered
// reset (synchronous, active high): tag sweep over all TableSlots slots, no items taken
// ----------------------------------------------------------------------------
// token_pair_rank_hash_table_unit
// open addressed token pair rank table, fmix64 hash, linear probing
// ----------------------------------------------------------------------------
`include "token_pair_rank_hash_table_unit_assert.svh"

module token_pair_rank_hash_table_unit import tprh_pkg::*; #(
   parameter int TableSlots = TABLE_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   tprh_req_if.sink    req_ch,
   tprh_rsp_if.source  rsp_ch,
   tprh_csr_if.sink    csr_ch
);

   localparam int IdxW  = $clog2(TableSlots);
   // largest size_log2 whose slot count fits the memory
   localparam int MaxLg = $clog2(TableSlots + 1) - 1;
   localparam int SlotW = $bits(slot_type);

   typedef enum logic [5:0] {
      S_SWEEP = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_READ  = 6'b001000,
      S_CMP   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [SIZE_LOG2_W-1:0] size_log2_ff, size_log2_in;
   logic [IdxW-1:0]        addr_ff, addr_in;
   logic [IdxW-1:0]        cnt_ff, cnt_in;
   logic [EPOCH_W-1:0]     epoch_ff, epoch_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // item payload and result holding
   logic [1:0]  op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic [31:0] rank_ff, rank_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_found_ff, res_found_in;
   logic [31:0] res_rank_ff, res_rank_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [31:0] rsp_rank_ff, rsp_rank_in;

   logic                   req_take;
   logic                   rsp_take;
   logic [SIZE_LOG2_W-1:0] lg_floor;
   logic [SIZE_LOG2_W-1:0] lg_eff;
   logic [IdxW-1:0]        mask;

   logic        mix_start;
   logic        mix_done;
   logic [31:0] mix_hash;

   logic             ram_wr_en;
   logic [SlotW-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [SlotW-1:0] ram_rd_data;
   slot_type         slot;
   slot_type         wr_slot;
   logic             slot_live;
   logic             slot_hit;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;
   // the user must write the register only while idle; the block does not enforce this and always takes writes
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.found    = rsp_found_ff;
   assign rsp_ch.rank_out = rsp_rank_ff;

   // ---------------------------------------------------------------------
   // active size: clamp to at least two slots and at most the memory
   // ---------------------------------------------------------------------
   always_comb begin
      lg_floor = (size_log2_ff == '0) ? SIZE_LOG2_W'(1) : size_log2_ff;
      lg_eff   = (int'(lg_floor) > MaxLg) ? SIZE_LOG2_W'(MaxLg) : lg_floor;
      for (int i = 0; i < IdxW; i++) begin
         mask[i] = (i < int'(lg_eff));
      end
   end

   assign size_log2_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.size_log2 : size_log2_ff;

   // ---------------------------------------------------------------------
   // slot decode: live only when its tag matches the current epoch
   // ---------------------------------------------------------------------
   assign slot      = slot_type'(ram_rd_data);
   assign slot_live = (slot.tag == epoch_ff);
   assign slot_hit  = slot_live && (slot.key == key_ff);

   always_comb begin
      wr_slot.tag  = epoch_ff;
      wr_slot.key  = key_ff;
      wr_slot.rank = rank_ff;
      if (state_ff == S_SWEEP) begin
         wr_slot = '0;
      end
   end

   assign ram_wr_data = SlotW'(wr_slot);
   assign ram_wr_en   = (state_ff == S_SWEEP) ||
                        ((state_ff == S_CMP) && !slot_live && (op_ff == OP_INSERT));
   assign ram_rd_en   = (state_ff == S_READ);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      epoch_in      = epoch_ff;
      pend_in       = pend_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      rank_in       = rank_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_rank_in   = res_rank_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      mix_start     = 1'b0;

      case (state_ff)
         S_SWEEP: begin
            // zero every tag, then restart epochs at one
            addr_in = addr_ff + IdxW'(1);
            if (addr_ff == IdxW'(TableSlots - 1)) begin
               addr_in  = '0;
               epoch_in = EPOCH_W'(1);
               pend_in  = 1'b0;
               state_in = pend_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               op_in         = req_ch.op;
               key_in        = {req_ch.left_id, req_ch.right_id};
               rank_in       = req_ch.rank_in;
               res_status_in = ST_OK;
               res_found_in  = 1'b0;
               res_rank_in   = '0;
               case (req_ch.op)
                  OP_LOOKUP, OP_INSERT: begin
                     mix_start = 1'b1;
                     state_in  = S_HASH;
                  end
                  OP_CLEAR: begin
                     // epoch bump drops every entry; sweep when the tag wraps
                     if (epoch_ff == '1) begin
                        pend_in  = 1'b1;
                        addr_in  = '0;
                        state_in = S_SWEEP;
                     end else begin
                        epoch_in = epoch_ff + EPOCH_W'(1);
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     // unused op code, plain ok
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (mix_done) begin
               addr_in  = mix_hash[IdxW-1:0] & mask;
               cnt_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_DONE;
            if (!slot_live) begin
               // free slot ends the walk; insert writes it this cycle
               if (op_ff != OP_INSERT) begin
                  res_status_in = ST_NOT_FOUND;
               end
            end else if (slot_hit) begin
               if (op_ff == OP_INSERT) begin
                  res_status_in = ST_DUP;
               end else begin
                  res_found_in = 1'b1;
                  res_rank_in  = slot.rank;
               end
            end else if (cnt_ff == mask) begin
               // every active slot visited
               res_status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            end else begin
               addr_in  = (addr_ff + IdxW'(1)) & mask;
               cnt_in   = cnt_ff + IdxW'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_rank_in   = res_rank_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         size_log2_ff <= SIZE_LOG2_RESET;
         addr_ff      <= '0;
         cnt_ff       <= '0;
         epoch_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_log2_ff <= size_log2_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         epoch_ff     <= epoch_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      rank_ff       <= rank_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_rank_ff   <= res_rank_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_rank_ff   <= rsp_rank_in;
   end

   // ---------------------------------------------------------------------
   // shared hash unit and slot memory
   // ---------------------------------------------------------------------
   tprh_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (key_in),
      .done  (mix_done),
      .hash  (mix_hash)
   );

   tprh_ram #(
      .Width (SlotW),
      .Depth (TableSlots)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `TPRH_ASSERT_SAME(a_found_is_ok, rsp_ch.valid && rsp_ch.found, rsp_ch.status == ST_OK, "found item with bad status")
   `TPRH_ASSERT_SAME(a_miss_rank_zero, rsp_ch.valid && !rsp_ch.found, rsp_ch.rank_out == '0, "rank on miss")
   `TPRH_ASSERT_SAME(a_epoch_live, state_ff != S_SWEEP, epoch_ff != '0, "zero epoch outside sweep")
   `TPRH_ASSERT_SAME(a_probe_bound, state_ff == S_CMP, (cnt_ff & ~mask) == '0, "probe count past size")
   `TPRH_ASSERT_SAME(a_hash_in_hash, mix_done, state_ff == S_HASH, "hash done outside hash wait")
   `TPRH_ASSERT_NEXT(a_insert_ends, ram_wr_en && (state_ff == S_CMP), state_ff == S_DONE, "insert kept walking")

endmodule
